FILE: rtl/core/asa_pkg.sv
// Shared types and constants for the audio superframe assembler.
// Used by asa_ctrl, asa_datapath and audio_superframe_assembler_unit; no dependencies.
package asa_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int BufBytesDef  = 4096;
  localparam int MaxFramesDef = 10;

  // Fixed field widths.
  localparam int ByteW   = 8;
  localparam int BorderW = 12;
  localparam int CntW    = 13;
  localparam int FrameIW = 4;
  localparam int OpW     = 2;
  localparam int CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegTenFrameMode = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPayloadLimit = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTotalBytes   = 2'd2;

  // Reset value of total_bytes.
  localparam logic [CntW-1:0] TotalBytesRst = 13'd4096;

  // Operation codes carried in the input tuser.
  typedef enum logic [OpW-1:0] {
    OP_LOAD  = 2'd0,
    OP_EMPTY = 2'd1,
    OP_FETCH = 2'd2
  } op_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_FORM
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // input beat accepted this cycle
    logic load_out;  // move the pending result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register is empty or drains this cycle
  } ctrl_sts_t;

endpackage

FILE: rtl/core/audio_superframe_assembler_unit.sv
// Top level of the audio superframe assembler.
// Depends on asa_pkg, asa_ctrl and asa_datapath.
//
//  channel  | signals                            | beat contents (low bit first)
//  ---------+------------------------------------+--------------------------------------
//  s_axis   | tvalid, tready, tdata, tlast, tuser| tdata byte_value, tlast frame_end,
//           |                                    | tuser operation
//  m_axis   | tvalid, tready, tdata, tlast, tuser| tdata out_byte, tlast out_last,
//           |                                    | tuser status
//  cfg      | cfg_we_i, cfg_index_i, cfg_data_i  | 0 ten_frame_mode, 1 payload_limit,
//           |                                    | 2 total_bytes
//
// Load and empty-frame beats are accepted directly in ST_IDLE. A fetch beat goes through
// the registered audio memory read, then waits in ST_FORM to fill the output register.
// The output register holds a result while the next beat is accepted; a second
// fetch waits in the controller only while that register is still occupied.
// Reset clears all counters and sets the configuration to its reset values; the stores are not cleared.
module audio_superframe_assembler_unit #(
  parameter int BUF_BYTES  = asa_pkg::BufBytesDef,
  parameter int MAX_FRAMES = asa_pkg::MaxFramesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [asa_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [asa_pkg::CntW-1:0]    cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] byte_value
  input  logic                        s_axis_tlast,
  input  logic [1:0]                  s_axis_tuser,   // [1:0] operation
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // [7:0] out_byte
  output logic                        m_axis_tlast,
  output logic [0:0]                  m_axis_tuser    // [0] status
);

  asa_pkg::ctrl_cmd_t       cmd;
  asa_pkg::ctrl_sts_t       sts;
  asa_pkg::state_e          state;
  logic [asa_pkg::CntW-1:0] audio_count;

  asa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  asa_datapath #(
    .BUF_BYTES  (BUF_BYTES),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_op_i       (s_axis_tuser),
    .in_byte_i     (s_axis_tdata),
    .in_end_i      (s_axis_tlast),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .out_last_o    (m_axis_tlast),
    .out_status_o  (m_axis_tuser[0]),
    .audio_count_o (audio_count)
  );

  // The output register is only loaded when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output beat overwritten before it was taken");

  // A fetch beat blocks the input for at least the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.take && (s_axis_tuser == asa_pkg::OP_FETCH)) |=> !s_axis_tready)
    else $error("input accepted during the fetch read cycle");

  // A new output beat only appears after a fetch was being formed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state == asa_pkg::ST_FORM))
    else $error("output beat without a pending fetch");

  // The audio fill count never runs past the buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {4'b0, audio_count} <= 17'(BUF_BYTES))
    else $error("audio fill count exceeds the buffer depth");

endmodule

FILE: rtl/core/asa_ctrl.sv
// Controller state machine of the audio superframe assembler.
// Depends on asa_pkg for the state, operation and command types.
module asa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_op_i,
  output logic              in_ready_o,
  input  asa_pkg::ctrl_sts_t sts_i,
  output asa_pkg::ctrl_cmd_t cmd_o,
  output asa_pkg::state_e   state_o
);

  asa_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= asa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands. A fetch registers the audio memory read when it is accepted
  // and then waits here until the output register can take the result.
  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o.take      = 1'b0;
    cmd_o.load_out  = 1'b0;
    unique case (state_q)
      asa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        if (in_valid_i && (asa_pkg::op_e'(in_op_i) == asa_pkg::OP_FETCH)) begin
          state_d = asa_pkg::ST_FORM;
        end
      end
      asa_pkg::ST_FORM: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = asa_pkg::ST_IDLE;
        end
      end
      default: state_d = asa_pkg::ST_IDLE;
    endcase
  end

  assign state_o = state_q;

endmodule

FILE: rtl/core/asa_datapath.sv
// Datapath of the audio superframe assembler: configuration, counters, border,
// CRC and audio stores, byte selection and the output register. Depends on asa_pkg.
module asa_datapath #(
  parameter int BUF_BYTES  = asa_pkg::BufBytesDef,
  parameter int MAX_FRAMES = asa_pkg::MaxFramesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration writes.
  input  logic                              cfg_we_i,
  input  logic [asa_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [asa_pkg::CntW-1:0]          cfg_data_i,
  // Input beat contents.
  input  logic [asa_pkg::OpW-1:0]           in_op_i,
  input  logic [asa_pkg::ByteW-1:0]         in_byte_i,
  input  logic                              in_end_i,
  // Controller interface.
  input  asa_pkg::ctrl_cmd_t                cmd_i,
  output asa_pkg::ctrl_sts_t                sts_o,
  // Output register.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [asa_pkg::ByteW-1:0]         out_byte_o,
  output logic                              out_last_o,
  output logic                              out_status_o,
  output logic [asa_pkg::CntW-1:0]          audio_count_o
);

  localparam int AW      = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
  localparam int NFive   = (MAX_FRAMES < 5) ? MAX_FRAMES : 5;
  localparam int NTen    = (MAX_FRAMES < 10) ? MAX_FRAMES : 10;
  localparam int NBord   = NTen - 1;
  localparam int HbFive  = ((NFive - 1) * 12 + 7) / 8;
  localparam int HbTen   = ((NTen - 1) * 12 + 4 + 7) / 8;
  localparam int HdrBits = HbTen * 8;
  localparam int LimCap  = (BUF_BYTES > 8191) ? 8191 : BUF_BYTES;
  localparam int CW      = asa_pkg::CntW;

  // Configuration registers.
  logic          mode_q;
  logic [CW-1:0] limit_q;
  logic [CW-1:0] total_q;

  // Superframe counters.
  logic [asa_pkg::FrameIW-1:0] fi_q, fi_d;
  logic [CW-1:0]               bif_q, bif_d;
  logic [asa_pkg::BorderW-1:0] rl_q, rl_d;
  logic [CW-1:0]               ac_q, ac_d;
  logic [CW-1:0]               rp_q, rp_d;
  logic                        ready_q, ready_d;

  // Stores.
  logic [asa_pkg::BorderW-1:0] border_q [NBord];
  logic [asa_pkg::ByteW-1:0]   crc_q [MAX_FRAMES];
  logic [asa_pkg::ByteW-1:0]   audio_mem_q [BUF_BYTES];
  logic [asa_pkg::ByteW-1:0]   mem_rd_q;

  // Pending fetch result.
  logic                      pend_use_mem_q, pend_use_mem_d;
  logic [asa_pkg::ByteW-1:0] pend_small_q, pend_small_d;
  logic                      pend_last_q, pend_last_d;
  logic                      pend_status_q, pend_status_d;

  // Output register.
  logic                      out_valid_q;
  logic [asa_pkg::ByteW-1:0] out_byte_q;
  logic                      out_last_q;
  logic                      out_status_q;

  // Derived values.
  asa_pkg::op_e              op;
  logic [3:0]                nfr;
  logic [3:0]                hb;
  logic [CW-1:0]             limit_eff;
  logic [CW-1:0]             total_eff;
  logic                      fi_ok;
  logic                      close;
  logic                      crc_we;
  logic [asa_pkg::ByteW-1:0] crc_wdata;
  logic                      brd_we;
  logic                      aud_we;
  logic                      fetch;
  logic [HdrBits-1:0]        hdr_flat;
  logic [asa_pkg::ByteW-1:0] hdr_byte;
  logic [asa_pkg::ByteW-1:0] crc_byte;
  logic [CW-1:0]             p1;
  logic [CW-1:0]             p2;
  logic                      is_hdr;
  logic                      is_crc;
  logic                      is_aud;
  logic [CW:0]               rp_inc;

  assign op        = asa_pkg::op_e'(in_op_i);
  assign nfr       = mode_q ? 4'(NTen) : 4'(NFive);
  assign hb        = mode_q ? 4'(HbTen) : 4'(HbFive);
  assign limit_eff = (limit_q > CW'(LimCap)) ? CW'(LimCap) : limit_q;
  assign total_eff = (total_q == '0) ? CW'(1) : total_q;
  assign fi_ok     = {1'b0, fi_q} < 5'(MAX_FRAMES);
  assign fetch     = cmd_i.take && (op == asa_pkg::OP_FETCH);
  assign rp_inc    = {1'b0, rp_q} + (CW+1)'(1);

  // Configuration writes; unused indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      limit_q <= '0;
      total_q <= asa_pkg::TotalBytesRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        asa_pkg::RegTenFrameMode: mode_q  <= cfg_data_i[0];
        asa_pkg::RegPayloadLimit: limit_q <= cfg_data_i;
        asa_pkg::RegTotalBytes:   total_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Header bits: borders MSB first, fields past the current frame count and
  // the pad nibble read as zero.
  always_comb begin
    hdr_flat = '0;
    for (int i = 0; i < NBord; i++) begin
      if (5'(i) < {1'b0, nfr} - 5'd1) begin
        hdr_flat[HdrBits-1-12*i -: 12] = border_q[i];
      end
    end
  end

  // Position decode of the byte being fetched.
  assign is_hdr = rp_q < CW'(hb);
  assign p1     = rp_q - CW'(hb);
  assign is_crc = p1 < CW'(nfr);
  assign p2     = p1 - CW'(nfr);
  assign is_aud = (p2 < ac_q) && (p2 < limit_eff);

  always_comb begin
    hdr_byte = '0;
    for (int j = 0; j < HbTen; j++) begin
      if (rp_q == CW'(j)) begin
        hdr_byte = hdr_flat[HdrBits-1-8*j -: 8];
      end
    end
  end

  always_comb begin
    crc_byte = '0;
    for (int k = 0; k < MAX_FRAMES; k++) begin
      if (p1 == CW'(k)) begin
        crc_byte = crc_q[k];
      end
    end
  end

  // Counter updates and store write strobes for the accepted beat.
  always_comb begin
    fi_d      = fi_q;
    bif_d     = bif_q;
    rl_d      = rl_q;
    ac_d      = ac_q;
    rp_d      = rp_q;
    ready_d   = ready_q;
    close     = 1'b0;
    crc_we    = 1'b0;
    crc_wdata = in_byte_i;
    brd_we    = 1'b0;
    aud_we    = 1'b0;
    if (cmd_i.take) begin
      unique case (op)
        asa_pkg::OP_LOAD: begin
          if (!ready_q) begin
            if (bif_q == '0) begin
              crc_we = fi_ok;
            end else begin
              if (ac_q < limit_eff) begin
                aud_we = 1'b1;
                ac_d   = ac_q + CW'(1);
              end
              rl_d = rl_q + asa_pkg::BorderW'(1);
            end
            if (bif_q != '1) begin
              bif_d = bif_q + CW'(1);
            end
            close = in_end_i;
          end
        end
        asa_pkg::OP_EMPTY: begin
          if (!ready_q) begin
            crc_we    = (bif_q == '0) && fi_ok;
            crc_wdata = '0;
            close     = 1'b1;
          end
        end
        asa_pkg::OP_FETCH: begin
          if (ready_q) begin
            if (rp_inc >= {1'b0, total_eff}) begin
              fi_d    = '0;
              bif_d   = '0;
              rl_d    = '0;
              ac_d    = '0;
              rp_d    = '0;
              ready_d = 1'b0;
            end else begin
              rp_d = rp_inc[CW-1:0];
            end
          end
        end
        default: ;
      endcase
    end
    // Frame close: record the border, step the frame index, detect completion.
    if (close) begin
      brd_we = ({1'b0, fi_q} + 5'd1 < {1'b0, nfr}) && ({1'b0, fi_q} < 5'(MAX_FRAMES - 1));
      fi_d   = fi_q + asa_pkg::FrameIW'(1);
      bif_d  = '0;
      if (fi_d >= nfr) begin
        ready_d = 1'b1;
        rp_d    = '0;
      end
    end
  end

  // Fetch result before the audio byte joins it.
  always_comb begin
    pend_status_d  = !ready_q;
    pend_last_d    = ready_q && (rp_inc >= {1'b0, total_eff});
    pend_use_mem_d = ready_q && !is_hdr && !is_crc && is_aud;
    pend_small_d   = '0;
    if (ready_q) begin
      if (is_hdr) begin
        pend_small_d = hdr_byte;
      end else if (is_crc) begin
        pend_small_d = crc_byte;
      end
    end
  end

  // Control counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fi_q    <= '0;
      bif_q   <= '0;
      rl_q    <= '0;
      ac_q    <= '0;
      rp_q    <= '0;
      ready_q <= 1'b0;
    end else begin
      fi_q    <= fi_d;
      bif_q   <= bif_d;
      rl_q    <= rl_d;
      ac_q    <= ac_d;
      rp_q    <= rp_d;
      ready_q <= ready_d;
    end
  end

  // Border and CRC stores, one register per entry.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NBord; i++) begin
      if (brd_we && (fi_q == asa_pkg::FrameIW'(i))) begin
        border_q[i] <= rl_d;
      end
    end
    for (int k = 0; k < MAX_FRAMES; k++) begin
      if (crc_we && (fi_q == asa_pkg::FrameIW'(k))) begin
        crc_q[k] <= crc_wdata;
      end
    end
  end

  // Audio memory: one write port at the fill count, one registered read port.
  always_ff @(posedge clk_i) begin
    if (aud_we) begin
      audio_mem_q[AW'(ac_q)] <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch) begin
      mem_rd_q <= audio_mem_q[AW'(p2)];
    end
  end

  // Pending result, captured when a fetch is accepted.
  always_ff @(posedge clk_i) begin
    if (fetch) begin
      pend_use_mem_q <= pend_use_mem_d;
      pend_small_q   <= pend_small_d;
      pend_last_q    <= pend_last_d;
      pend_status_q  <= pend_status_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_byte_q   <= pend_use_mem_q ? mem_rd_q : pend_small_q;
      out_last_q   <= pend_last_q;
      out_status_q <= pend_status_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign out_last_o     = out_last_q;
  assign out_status_o   = out_status_q;
  assign audio_count_o  = ac_q;

endmodule

FILE: bench/audio_superframe_assembler_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for audio_superframe_assembler_unit: superframes are loaded and fetched
// over the stream ports and every output beat is checked against an in-bench prediction.
// Depends on asa_pkg and the assembler RTL.
module audio_superframe_assembler_unit_test;

  localparam logic [asa_pkg::OpW-1:0] OpUnused = 2'd3;
  localparam int unsigned CycleLimit     = 1000000;
  localparam int unsigned SettleCycles   = 4;
  localparam int unsigned RandomBeats    = 1050;
  localparam int unsigned QuietFrom      = 950;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned LongFrameBytes = 64;
  localparam int unsigned BigTotalBytes  = 80;
  localparam int unsigned BigPhase       = 5;

  typedef struct packed {
    logic [asa_pkg::OpW-1:0] op;
    logic [7:0]              data;
    logic                    last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       pending;
  } tx_byte_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [asa_pkg::CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [asa_pkg::CntW-1:0]     cfg_data_i    = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata  = '0;  // [7:0] byte_value
  logic                         s_axis_tlast  = 1'b0;
  logic [1:0]                   s_axis_tuser  = '0;  // [1:0] operation
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [7:0]                   m_axis_tdata;        // [7:0] out_byte
  logic                         m_axis_tlast;
  logic [0:0]                   m_axis_tuser;        // [0] status

  audio_superframe_assembler_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Stimulus queue, expected output bytes and run bookkeeping.
  in_beat_t    beats_pending[$];
  tx_byte_t    tx_expected[$];
  int unsigned error_count = 0;
  int unsigned stim_count  = 0;
  int unsigned cycle_count = 0;
  bit          tx_idle_on  = 1'b0;
  bit          rx_idle_on  = 1'b0;
  bit          long_hold_req = 1'b0;

  // Predicted assembler state and configuration.
  logic        sf_ten_mode;
  int unsigned sf_payload;
  int unsigned sf_total;
  logic [11:0] sf_borders[0:asa_pkg::MaxFramesDef-2];
  logic [7:0]  sf_crcs[0:asa_pkg::MaxFramesDef-1];
  logic [7:0]  sf_audio[0:asa_pkg::BufBytesDef-1];
  int unsigned sf_frame;
  int unsigned sf_in_frame;
  int unsigned sf_length;
  int unsigned sf_audio_cnt;
  int unsigned sf_rd_pos;
  bit          sf_ready;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  function automatic int unsigned frames_in();
    return sf_ten_mode ? 10 : 5;
  endfunction

  function automatic int unsigned header_len();
    return ((frames_in() - 1) * 12 + (sf_ten_mode ? 4 : 0) + 7) / 8;
  endfunction

  function automatic int unsigned audio_cap();
    return (sf_payload > asa_pkg::BufBytesDef) ? asa_pkg::BufBytesDef : sf_payload;
  endfunction

  function automatic int unsigned total_len();
    return (sf_total == 0) ? 1 : sf_total;
  endfunction

  function automatic void clear_counters();
    sf_frame     = 0;
    sf_in_frame  = 0;
    sf_length    = 0;
    sf_audio_cnt = 0;
    sf_rd_pos    = 0;
    sf_ready     = 1'b0;
  endfunction

  // Store the border of the frame just closed and see whether the superframe is complete.
  function automatic void finish_frame();
    if (sf_frame + 1 < frames_in() && sf_frame < asa_pkg::MaxFramesDef - 1)
      sf_borders[sf_frame] = sf_length[11:0];
    sf_frame    = (sf_frame + 1) & 32'hF;
    sf_in_frame = 0;
    if (sf_frame >= frames_in()) begin
      sf_ready  = 1'b1;
      sf_rd_pos = 0;
    end
  endfunction

  // One byte of the transmission frame: borders, pad, CRCs, audio, then zero fill.
  function automatic logic [7:0] frame_byte_at(input int unsigned pos);
    int unsigned n;
    int unsigned nbits;
    int unsigned b;
    logic [7:0]  v;
    n     = frames_in();
    nbits = (n - 1) * 12;
    v     = '0;
    if (pos < header_len()) begin
      for (int k = 0; k < 8; k++) begin
        b = pos * 8 + k;
        v = {v[6:0], (b < nbits) ? sf_borders[b / 12][11 - b % 12] : 1'b0};
      end
      return v;
    end
    pos -= header_len();
    if (pos < n) return (pos < asa_pkg::MaxFramesDef) ? sf_crcs[pos] : 8'h00;
    pos -= n;
    if (pos < sf_audio_cnt && pos < audio_cap()) return sf_audio[pos];
    return 8'h00;
  endfunction

  // Apply one accepted input beat and queue the output byte it causes, if any.
  function automatic void superframe_step(input in_beat_t beat);
    tx_byte_t res;
    case (beat.op)
      asa_pkg::OP_LOAD: begin
        if (!sf_ready) begin
          if (sf_in_frame == 0) begin
            if (sf_frame < asa_pkg::MaxFramesDef) sf_crcs[sf_frame] = beat.data;
          end else begin
            if (sf_audio_cnt < audio_cap()) begin
              sf_audio[sf_audio_cnt] = beat.data;
              sf_audio_cnt++;
            end
            sf_length = (sf_length + 1) & 32'hFFF;
          end
          if (sf_in_frame < 8191) sf_in_frame++;
          if (beat.last) finish_frame();
        end
      end
      asa_pkg::OP_EMPTY: begin
        if (!sf_ready) begin
          if (sf_in_frame == 0 && sf_frame < asa_pkg::MaxFramesDef) sf_crcs[sf_frame] = 8'h00;
          finish_frame();
        end
      end
      asa_pkg::OP_FETCH: begin
        if (!sf_ready) begin
          res = '{value: 8'h00, last: 1'b0, pending: 1'b1};
        end else begin
          res.value   = frame_byte_at(sf_rd_pos);
          res.pending = 1'b0;
          res.last    = (sf_rd_pos + 1 >= total_len());
          if (res.last) clear_counters();
          else sf_rd_pos = (sf_rd_pos + 1) & 32'h1FFF;
        end
        tx_expected.insert(tx_expected.size(), res);
      end
      default: ;
    endcase
  endfunction

  // Check accepted output beats, track register writes and predict from accepted inputs.
  always @(posedge clk_i) begin
    tx_byte_t want;
    if (!rst_ni) begin
      sf_ten_mode = 1'b0;
      sf_payload  = 0;
      sf_total    = 32'(asa_pkg::TotalBytesRst);
      clear_counters();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (tx_expected.size() == 0) begin
          report_mismatch($sformatf("output beat %02h with nothing expected", m_axis_tdata));
        end else begin
          want = tx_expected.pop_front();
          if (m_axis_tdata !== want.value)
            report_mismatch($sformatf("out_byte %02h, want %02h", m_axis_tdata, want.value));
          if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("out_last %b, want %b", m_axis_tlast, want.last));
          if (m_axis_tuser[0] !== want.pending)
            report_mismatch($sformatf("status %b, want %b", m_axis_tuser[0], want.pending));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          asa_pkg::RegTenFrameMode: sf_ten_mode = cfg_data_i[0];
          asa_pkg::RegPayloadLimit: sf_payload  = 32'(cfg_data_i);
          asa_pkg::RegTotalBytes:   sf_total    = 32'(cfg_data_i);
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        superframe_step('{op: s_axis_tuser, data: s_axis_tdata, last: s_axis_tlast});
    end
  end

  // Input driver: holds a beat until accepted, with random idle bursts between beats.
  int unsigned tx_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    in_beat_t beat;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      s_axis_tuser  <= asa_pkg::OP_LOAD;
      tx_gap        <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tx_gap != 0) begin
        tx_gap        <= tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (beats_pending.size() != 0) begin
        beat = beats_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat.data;
        s_axis_tlast  <= beat.last;
        s_axis_tuser  <= beat.op;
        if (tx_idle_on && $urandom_range(0, 5) == 0) tx_gap <= $urandom_range(1, 10);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output side: random stall bursts, plus one long hold-off while fetches keep coming.
  int unsigned rx_stall = 0;
  int unsigned long_hold_left = 0;
  bit          long_hold_used = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready  <= 1'b1;
      rx_stall       <= 0;
      long_hold_left <= 0;
      long_hold_used <= 1'b0;
    end else if (long_hold_req && !long_hold_used) begin
      long_hold_used <= 1'b1;
      long_hold_left <= LongHoldCycles;
      m_axis_tready  <= 1'b0;
    end else if (long_hold_left != 0) begin
      long_hold_left <= long_hold_left - 1;
      m_axis_tready  <= 1'b0;
    end else if (rx_stall != 0) begin
      rx_stall      <= rx_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_stall      <= $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [asa_pkg::CfgIdxW-1:0] idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[asa_pkg::CntW-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Blocks until every beat is sent and every expected byte has come back.
  task automatic wait_drained();
    while (beats_pending.size() != 0 || s_axis_tvalid || tx_expected.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic queue_beat(input logic [asa_pkg::OpW-1:0] op, input logic [7:0] data,
                            input logic last, input bit tally);
    in_beat_t beat;
    beat = '{op: op, data: data, last: last};
    beats_pending.insert(beats_pending.size(), beat);
    if (tally) stim_count++;
  endtask

  task automatic queue_loads(input int unsigned count, input bit close, input bit tally);
    for (int unsigned i = 0; i < count; i++)
      queue_beat(asa_pkg::OP_LOAD, 8'($urandom), close && (i == count - 1), tally);
  endtask

  // Frames up to completion (or a random part of them), with noise in between.
  task automatic queue_superframe(input bit partial, input bit long_first, input bit tally);
    int unsigned need;
    int unsigned stop;
    int unsigned kind;
    need = (sf_frame >= frames_in()) ? 1 : frames_in() - sf_frame;
    stop = partial ? $urandom_range(0, need - 1) : need;
    for (int unsigned f = 0; f < stop; f++) begin
      if ($urandom_range(0, 15) == 0) queue_beat(OpUnused, 8'($urandom), 1'($urandom), 1'b0);
      // A fetch before the last frame closes only reports status.
      if ($urandom_range(0, 11) == 0)
        queue_beat(asa_pkg::OP_FETCH, 8'($urandom), 1'($urandom), tally);
      kind = $urandom_range(0, 9);
      if (long_first && f == 0) begin
        queue_loads(LongFrameBytes, 1'b1, tally);
      end else if (kind == 0) begin
        queue_beat(asa_pkg::OP_EMPTY, 8'($urandom), 1'($urandom), tally);
      end else if (kind == 1) begin
        queue_loads($urandom_range(1, 4), 1'b0, tally);
        queue_beat(asa_pkg::OP_EMPTY, 8'($urandom), 1'($urandom), tally);
      end else begin
        queue_loads((kind == 2) ? $urandom_range(10, 40) : $urandom_range(1, 9), 1'b1, tally);
      end
    end
  endtask

  // Fetches of a completed superframe; loads slipped in between are dropped by the block.
  task automatic queue_fetches(input int unsigned count, input bit tally);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0)
        queue_beat($urandom_range(0, 1) ? asa_pkg::OP_LOAD : asa_pkg::OP_EMPTY,
                   8'($urandom), 1'($urandom), 1'b0);
      if ($urandom_range(0, 39) == 0) queue_beat(OpUnused, 8'($urandom), 1'($urandom), 1'b0);
      queue_beat(asa_pkg::OP_FETCH, 8'($urandom), 1'($urandom), tally);
    end
  endtask

  task automatic run_phase(input int unsigned phase);
    bit          partial;
    int unsigned tot;
    wait_drained();
    // Finish a superframe left waiting so that the mode may change safely.
    if (sf_ready) begin
      queue_fetches(total_len() - sf_rd_pos, 1'b1);
      wait_drained();
    end

    case (phase)
      2: write_reg(asa_pkg::RegTotalBytes, 0);
      3: begin
        write_reg(asa_pkg::RegTenFrameMode, 1);
        write_reg(asa_pkg::RegPayloadLimit, 8191);
        write_reg(asa_pkg::RegTotalBytes, 40);
      end
      4: begin
        write_reg(asa_pkg::RegPayloadLimit, 0);
        write_reg(asa_pkg::RegTotalBytes, 1);
      end
      BigPhase: begin
        write_reg(asa_pkg::RegTenFrameMode, 1);
        write_reg(asa_pkg::RegPayloadLimit, 4096);
        write_reg(asa_pkg::RegTotalBytes, BigTotalBytes);
      end
      default: begin
        if ($urandom_range(0, 2) == 0)
          write_reg(asa_pkg::RegTenFrameMode, $urandom_range(0, 1));
        if ($urandom_range(0, 2) == 0)
          write_reg(asa_pkg::RegPayloadLimit,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 40));
        if ($urandom_range(0, 2) == 0)
          write_reg(asa_pkg::RegTotalBytes,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 48));
      end
    endcase

    if (phase == BigPhase || stim_count > QuietFrom) begin
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
    end else begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
    end

    if (phase == BigPhase) begin
      // A long first frame in ten-frame mode, then the receiver holds off while the
      // full-length fetch run backs up into the input.
      queue_superframe(1'b0, 1'b1, 1'b1);
      while (beats_pending.size() != 0) @(negedge clk_i);
      long_hold_req = 1'b1;
      queue_fetches(total_len(), 1'b1);
    end else begin
      partial = ($urandom_range(0, 7) == 0);
      queue_superframe(partial, 1'b0, 1'b1);
      if (!partial) begin
        tot = total_len();
        if (tot > 1 && $urandom_range(0, 7) == 0) tot = $urandom_range(1, tot - 1);
        queue_fetches(tot, 1'b1);
      end
    end
  endtask

  initial begin
    int unsigned phase;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Five-frame superframe with a small payload limit: header 6, CRCs 5, audio 3 bytes.
    write_reg(asa_pkg::RegTenFrameMode, 0);
    write_reg(asa_pkg::RegPayloadLimit, 5);
    write_reg(asa_pkg::RegTotalBytes, 14);
    queue_beat(asa_pkg::OP_FETCH, 8'h00, 1'b0, 1'b0);   // not complete yet
    queue_beat(OpUnused, 8'hFF, 1'b1, 1'b0);
    queue_beat(asa_pkg::OP_LOAD, 8'hFF, 1'b0, 1'b0);
    queue_beat(asa_pkg::OP_LOAD, 8'h00, 1'b0, 1'b0);
    queue_beat(asa_pkg::OP_LOAD, 8'hFF, 1'b1, 1'b0);
    queue_beat(asa_pkg::OP_EMPTY, 8'hA5, 1'b1, 1'b0);   // empty frame writes CRC zero
    queue_beat(asa_pkg::OP_LOAD, 8'h5A, 1'b0, 1'b0);
    queue_beat(asa_pkg::OP_LOAD, 8'h11, 1'b0, 1'b0);
    queue_beat(asa_pkg::OP_LOAD, 8'h22, 1'b0, 1'b0);
    queue_beat(asa_pkg::OP_LOAD, 8'h33, 1'b0, 1'b0);
    queue_beat(asa_pkg::OP_LOAD, 8'h44, 1'b1, 1'b0);    // beyond the payload limit
    queue_beat(asa_pkg::OP_LOAD, 8'h81, 1'b0, 1'b0);
    queue_beat(asa_pkg::OP_LOAD, 8'h7E, 1'b0, 1'b0);
    queue_beat(asa_pkg::OP_EMPTY, 8'h00, 1'b0, 1'b0);   // closes a partly loaded frame
    queue_beat(asa_pkg::OP_LOAD, 8'hC3, 1'b1, 1'b0);
    queue_beat(asa_pkg::OP_LOAD, 8'h12, 1'b1, 1'b0);    // dropped while the frame waits
    queue_beat(asa_pkg::OP_EMPTY, 8'h34, 1'b0, 1'b0);   // dropped as well
    for (int i = 0; i < 14; i++) queue_beat(asa_pkg::OP_FETCH, 8'h00, 1'b0, 1'b0);

    phase = 0;
    while (stim_count < RandomBeats || phase <= BigPhase) begin
      run_phase(phase);
      phase++;
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
